// File: hw/rtl/serial_frame_checker_crc16_unit_macros.svh
// Assertion helpers shared by the frame checker RTL.
`ifndef SERIAL_FRAME_CHECKER_CRC16_UNIT_MACROS_SVH
`define SERIAL_FRAME_CHECKER_CRC16_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

// File: hw/rtl/sfc16_pkg.sv
package sfc16_pkg;

  localparam int MAX_PAYLOAD = 1024;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;

  localparam logic [10:0] HEADER_BYTES = 11'd10;
  localparam logic [10:0] INDEX_LIMIT  = 11'd2047;

  // Header byte offsets
  localparam logic [3:0] OFS_MAGIC0   = 4'd0;
  localparam logic [3:0] OFS_MAGIC1   = 4'd1;
  localparam logic [3:0] OFS_VERSION  = 4'd2;
  localparam logic [3:0] OFS_FLAGS    = 4'd3;
  localparam logic [3:0] OFS_SEQUENCE = 4'd4;
  localparam logic [3:0] OFS_COMMAND  = 4'd5;
  localparam logic [3:0] OFS_STATUS   = 4'd6;
  localparam logic [3:0] OFS_LEN_LO   = 4'd8;
  localparam logic [3:0] OFS_LEN_HI   = 4'd9;

  // Configuration register indexes
  localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
  localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] REG_VERSION      = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);

  typedef enum logic [2:0] {
    VERD_OK          = 3'd0,
    VERD_SHORT       = 3'd1,
    VERD_BAD_MAGIC   = 3'd2,
    VERD_BAD_VERSION = 3'd3,
    VERD_TOO_LONG    = 3'd4,
    VERD_BAD_CRC     = 3'd5
  } verdict_t;

  typedef struct packed {
    logic        run_end;
    logic        kind;
    logic [10:0] payload_length;
    logic [7:0]  header_status;
    logic [7:0]  command_code;
    logic [7:0]  sequence_res;
    logic [7:0]  frame_flags;
    verdict_t    verdict;
    logic [7:0]  payload_data;
  } result_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] v;
    v = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/serial_frame_checker_crc16_unit.sv
// Framed packet checker. Bytes of a received buffer enter on the s_axis side,
// one per item, with tlast on the final byte. A frame is a 10-byte header
// (magic, magic, version, flags, sequence, command, status, reserved, length
// low, length high), the payload, and a little-endian CRC-16/CCITT-FALSE over
// header and payload. Payload bytes leave on m_axis (tuser = 0) as they
// arrive, once magic, version and length have checked out; tlast on a byte
// adds a verdict item (tuser = 1) carrying the header fields when the frame
// is good, and starts a new buffer. Bytes past the CRC, and bytes from
// index 2047 on, change nothing. Rate: one byte per clock while the output
// is ready and each byte causes at most one result; a byte that causes both
// a payload item and a verdict queues both, to leave one at a time. Each byte is
// worked in the cycle it is accepted (byte-wide CRC step, header compare) and
// its results drop into a 4-entry result queue; s_axis_tready is high while
// the queue has room for two results, so input keeps flowing while output
// stalls briefly. The verdict is registered into the queue when the tlast
// byte is accepted, behind any items already queued. Configuration writes
// take effect at once and are meant for idle periods.
`include "serial_frame_checker_crc16_unit_macros.svh"

module serial_frame_checker_crc16_unit #(
  parameter int MAX_PAYLOAD = sfc16_pkg::MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // buffer_end
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_data, [10:8] verdict, [18:11] frame_flags,
  // [26:19] sequence_res, [34:27] command_code, [42:35] header_status,
  // [53:43] payload_length, [55:54] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast    // run_end
);

  localparam int PW = sfc16_pkg::RES_PTR_W;
  localparam int CW = $clog2(sfc16_pkg::RES_DEPTH + 1);

  // Configuration registers
  logic [7:0] magic_first;
  logic [7:0] magic_second;
  logic [7:0] expected_version;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first      <= '0;
      magic_second     <= '0;
      expected_version <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sfc16_pkg::REG_MAGIC_FIRST:  magic_first      <= cfg_data;
        sfc16_pkg::REG_MAGIC_SECOND: magic_second     <= cfg_data;
        sfc16_pkg::REG_VERSION:      expected_version <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame state
  logic [10:0] byte_index,       byte_index_next;
  logic [15:0] running_crc,      running_crc_next;
  logic [7:0]  held_flags,       held_flags_next;
  logic [7:0]  held_sequence,    held_sequence_next;
  logic [7:0]  held_command,     held_command_next;
  logic [7:0]  held_status,      held_status_next;
  logic [15:0] held_length,      held_length_next;
  logic [7:0]  received_crc_low, received_crc_low_next;
  logic        magic_mismatch,   magic_mismatch_next;
  logic        version_mismatch, version_mismatch_next;

  // Result queue
  sfc16_pkg::result_t res_q [sfc16_pkg::RES_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] res_count;

  logic in_acc, out_acc;
  logic [7:0] data;
  logic       buf_end;

  assign data    = s_axis_tdata;
  assign buf_end = s_axis_tlast;

  assign s_axis_tready = (res_count <= CW'(sfc16_pkg::RES_DEPTH - 2));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (res_count != '0);
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  logic [10:0] off;
  logic [15:0] off_ext;
  logic [16:0] plen_p1;
  logic        hdr_ok;
  logic        fwd;
  logic [16:0] frame_need;
  sfc16_pkg::verdict_t verd;
  logic        verd_ok;
  sfc16_pkg::result_t res_pay, res_verd, res_a, res_b;
  logic        push_a, push_b;

  assign off     = byte_index - sfc16_pkg::HEADER_BYTES;
  assign off_ext = {5'b0, off};
  assign plen_p1 = {1'b0, held_length} + 17'd1;
  assign hdr_ok  = !magic_mismatch && !version_mismatch &&
                   (32'(held_length) <= 32'(MAX_PAYLOAD));

  // Per-byte update: header capture, CRC step, payload forward, CRC capture.
  always_comb begin
    byte_index_next       = byte_index;
    running_crc_next      = running_crc;
    held_flags_next       = held_flags;
    held_sequence_next    = held_sequence;
    held_command_next     = held_command;
    held_status_next      = held_status;
    held_length_next      = held_length;
    received_crc_low_next = received_crc_low;
    magic_mismatch_next   = magic_mismatch;
    version_mismatch_next = version_mismatch;
    fwd                   = 1'b0;

    if (byte_index != sfc16_pkg::INDEX_LIMIT) begin
      if (byte_index < sfc16_pkg::HEADER_BYTES) begin
        running_crc_next = sfc16_pkg::crc16_byte(running_crc, data);
        case (byte_index[3:0])
          sfc16_pkg::OFS_MAGIC0:   if (data != magic_first) magic_mismatch_next = 1'b1;
          sfc16_pkg::OFS_MAGIC1:   if (data != magic_second) magic_mismatch_next = 1'b1;
          sfc16_pkg::OFS_VERSION:  if (data != expected_version) version_mismatch_next = 1'b1;
          sfc16_pkg::OFS_FLAGS:    held_flags_next    = data;
          sfc16_pkg::OFS_SEQUENCE: held_sequence_next = data;
          sfc16_pkg::OFS_COMMAND:  held_command_next  = data;
          sfc16_pkg::OFS_STATUS:   held_status_next   = data;
          sfc16_pkg::OFS_LEN_LO:   held_length_next   = {8'h00, data};
          sfc16_pkg::OFS_LEN_HI:   held_length_next   = {data, held_length[7:0]};
          default: ;
        endcase
      end else if (off_ext < held_length) begin
        running_crc_next = sfc16_pkg::crc16_byte(running_crc, data);
        fwd              = hdr_ok;
      end else if (off_ext == held_length) begin
        received_crc_low_next = data;
      end else if ({1'b0, off_ext} == plen_p1) begin
        // fold the wire CRC in: zero afterwards means a match
        running_crc_next = running_crc ^ {data, received_crc_low};
      end
      byte_index_next = byte_index + 11'd1;
    end
  end

  // Verdict, in priority order, from the state after this byte.
  assign frame_need = {1'b0, held_length_next} + 17'd12;

  always_comb begin
    if (byte_index_next < sfc16_pkg::HEADER_BYTES) begin
      verd = sfc16_pkg::VERD_SHORT;
    end else if (magic_mismatch_next) begin
      verd = sfc16_pkg::VERD_BAD_MAGIC;
    end else if (version_mismatch_next) begin
      verd = sfc16_pkg::VERD_BAD_VERSION;
    end else if (32'(held_length_next) > 32'(MAX_PAYLOAD)) begin
      verd = sfc16_pkg::VERD_TOO_LONG;
    end else if ({6'b0, byte_index_next} < frame_need) begin
      verd = sfc16_pkg::VERD_SHORT;
    end else if (running_crc_next != 16'h0000) begin
      verd = sfc16_pkg::VERD_BAD_CRC;
    end else begin
      verd = sfc16_pkg::VERD_OK;
    end
  end

  assign verd_ok = (verd == sfc16_pkg::VERD_OK);

  always_comb begin
    res_pay                = '0;
    res_pay.kind           = sfc16_pkg::KIND_PAYLOAD;
    res_pay.payload_data   = data;
    res_pay.verdict        = sfc16_pkg::VERD_OK;
    res_pay.run_end        = !buf_end;

    res_verd                = '0;
    res_verd.kind           = sfc16_pkg::KIND_VERDICT;
    res_verd.verdict        = verd;
    res_verd.run_end        = 1'b1;
    if (verd_ok) begin
      res_verd.frame_flags    = held_flags_next;
      res_verd.sequence_res   = held_sequence_next;
      res_verd.command_code   = held_command_next;
      res_verd.header_status  = held_status_next;
      res_verd.payload_length = held_length_next[10:0];
    end
  end

  // Payload item goes first, the verdict after it.
  assign res_a  = fwd ? res_pay : res_verd;
  assign res_b  = res_verd;
  assign push_a = in_acc && (fwd || buf_end);
  assign push_b = in_acc && fwd && buf_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index       <= '0;
      running_crc      <= sfc16_pkg::CRC_SEED;
      held_flags       <= '0;
      held_sequence    <= '0;
      held_command     <= '0;
      held_status      <= '0;
      held_length      <= '0;
      received_crc_low <= '0;
      magic_mismatch   <= 1'b0;
      version_mismatch <= 1'b0;
    end else if (in_acc) begin
      if (buf_end) begin
        // verdict given: start a new buffer
        byte_index       <= '0;
        running_crc      <= sfc16_pkg::CRC_SEED;
        held_flags       <= '0;
        held_sequence    <= '0;
        held_command     <= '0;
        held_status      <= '0;
        held_length      <= '0;
        received_crc_low <= '0;
        magic_mismatch   <= 1'b0;
        version_mismatch <= 1'b0;
      end else begin
        byte_index       <= byte_index_next;
        running_crc      <= running_crc_next;
        held_flags       <= held_flags_next;
        held_sequence    <= held_sequence_next;
        held_command     <= held_command_next;
        held_status      <= held_status_next;
        held_length      <= held_length_next;
        received_crc_low <= received_crc_low_next;
        magic_mismatch   <= magic_mismatch_next;
        version_mismatch <= version_mismatch_next;
      end
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push_a) begin
      res_q[wr_ptr] <= res_a;
    end
    if (push_b) begin
      res_q[wr_ptr + PW'(1)] <= res_b;
    end
  end

  logic [CW-1:0] push_n;
  assign push_n = CW'(push_a) + CW'(push_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      res_count <= '0;
    end else begin
      wr_ptr    <= wr_ptr + push_n[PW-1:0];
      if (out_acc) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      res_count <= res_count + push_n - CW'(out_acc);
    end
  end

  sfc16_pkg::result_t res_head;
  assign res_head = res_q[rd_ptr];

  assign m_axis_tdata = {2'b00,
                         res_head.payload_length,
                         res_head.header_status,
                         res_head.command_code,
                         res_head.sequence_res,
                         res_head.frame_flags,
                         res_head.verdict,
                         res_head.payload_data};
  assign m_axis_tuser = res_head.kind;
  assign m_axis_tlast = res_head.run_end;

  // Checks
  `SFC_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, res_count <= CW'(sfc16_pkg::RES_DEPTH))
  `SFC_ASSERT_NEXT(a_end_clears, clk, rst, in_acc && s_axis_tlast,
    byte_index == '0 && running_crc == sfc16_pkg::CRC_SEED)
  `SFC_ASSERT_NEXT(a_index_saturates, clk, rst,
    in_acc && !s_axis_tlast && byte_index == sfc16_pkg::INDEX_LIMIT,
    byte_index == sfc16_pkg::INDEX_LIMIT && $stable(running_crc))
  `SFC_ASSERT_NEXT(a_pop_only, clk, rst, out_acc && !in_acc,
    res_count == $past(res_count) - CW'(1))

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int SETTLE_CYCLES  = 8;     // quiet cycles before a register write or the end
  localparam int PHASE_BYTES    = 135;   // minimum of random bytes per register setting
  localparam int JUMBO_BYTES    = 2060;  // long buffer that runs the byte index into saturation
  localparam logic [1:0] REG_UNUSED = 2'd3;  // index past the register list

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI} byte_src_t;

  // One directed step: a byte to send or a register write. A byte row may carry
  // a verdict typed in by hand; that row must cause the verdict item alone.
  typedef struct {
    row_kind_t           kind;
    logic [1:0]          reg_idx;
    logic [7:0]          val;
    byte_src_t           src;
    logic                last;
    logic                typed;
    sfc16_pkg::verdict_t tverd;
  } step_t;

  typedef struct packed {
    logic                kind;
    logic [7:0]          pay;
    sfc16_pkg::verdict_t verdict;
    logic [7:0]          flags;
    logic [7:0]          seq;
    logic [7:0]          cmd;
    logic [7:0]          stat;
    logic [10:0]         len;
    logic                run_end;
  } frame_item_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tlast;   // buffer_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] payload_data, [10:8] verdict, [18:11] frame_flags, [26:19] sequence_res,
  // [34:27] command_code, [42:35] header_status, [53:43] payload_length, [55:54] zero
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;   // kind
  logic        m_axis_tlast;   // run_end

  serial_frame_checker_crc16_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Frame checker model: registers and per-buffer state.
  logic [7:0]  want_magic0, want_magic1, want_version;
  logic [10:0] fc_index;
  logic [15:0] fc_crc;
  logic [7:0]  fc_flags, fc_seq, fc_cmd, fc_stat;
  logic [15:0] fc_length;
  logic [7:0]  fc_crc_low;
  logic        fc_magic_bad, fc_version_bad;

  frame_item_t frame_results_due[$];  // items the block still owes, oldest first
  frame_item_t got, want;
  int          mismatches;
  int          quiet_cycles;
  bit          steady;                // drop all idling on both sides

  // Directed steps. Registers start at reset value zero, so a lone byte is short.
  // The good frame carries a one-byte payload and one trailing byte after its CRC;
  // the last frame breaks both the second magic and the version, and magic wins.
  step_t steps[$] = '{
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h5A, SRC_LIT, 1'b1, 1'b1, sfc16_pkg::VERD_SHORT},
    '{ROW_CFG, sfc16_pkg::REG_MAGIC_FIRST, 8'hFF, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_CFG, sfc16_pkg::REG_MAGIC_SECOND, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_CFG, sfc16_pkg::REG_VERSION, 8'hFF, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_CFG, REG_UNUSED, 8'h55, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'hFF, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'hFF, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'hFF, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h80, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h01, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h7F, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h01, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h5A, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_CRC_LO, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_CRC_HI, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'hAB, SRC_LIT, 1'b1, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'hFF, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h01, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b0, 1'b0, sfc16_pkg::VERD_OK},
    '{ROW_BYTE, sfc16_pkg::REG_MAGIC_FIRST, 8'h00, SRC_LIT, 1'b1, 1'b1,
      sfc16_pkg::VERD_BAD_MAGIC}
  };

  // CRC-16/CCITT-FALSE, one byte, MSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    int          k;
    r = c ^ {b, 8'h00};
    for (k = 0; k < 8; k++)
      r = r[15] ? ({r[14:0], 1'b0} ^ sfc16_pkg::CRC_POLY) : {r[14:0], 1'b0};
    return r;
  endfunction

  function automatic string item_text(input frame_item_t it);
    return $sformatf({"kind=%0d pay=%02h verd=%0d flags=%02h seq=%02h cmd=%02h",
                      " st=%02h len=%0d last=%0d"},
                     it.kind, it.pay, it.verdict, it.flags, it.seq, it.cmd, it.stat, it.len,
                     it.run_end);
  endfunction

  task automatic clear_frame_state();
    fc_index       = '0;
    fc_crc         = sfc16_pkg::CRC_SEED;
    fc_flags       = '0;
    fc_seq         = '0;
    fc_cmd         = '0;
    fc_stat        = '0;
    fc_length      = '0;
    fc_crc_low     = '0;
    fc_magic_bad   = 1'b0;
    fc_version_bad = 1'b0;
  endtask

  // Advance the frame state by one accepted byte and queue the items it causes.
  task automatic predict_byte(input logic [7:0] b, input logic e);
    int                  pos, plen, off, cnt;
    bit                  hdr_ok, fwd;
    sfc16_pkg::verdict_t v;
    frame_item_t         it;
    pos    = fc_index;
    plen   = fc_length;
    hdr_ok = !fc_magic_bad && !fc_version_bad && plen <= sfc16_pkg::MAX_PAYLOAD;
    fwd    = 1'b0;
    if (pos < sfc16_pkg::INDEX_LIMIT) begin
      if (pos < sfc16_pkg::HEADER_BYTES) begin
        fc_crc = crc16_step(fc_crc, b);
        case (pos)
          sfc16_pkg::OFS_MAGIC0:   if (b != want_magic0) fc_magic_bad = 1'b1;
          sfc16_pkg::OFS_MAGIC1:   if (b != want_magic1) fc_magic_bad = 1'b1;
          sfc16_pkg::OFS_VERSION:  if (b != want_version) fc_version_bad = 1'b1;
          sfc16_pkg::OFS_FLAGS:    fc_flags = b;
          sfc16_pkg::OFS_SEQUENCE: fc_seq = b;
          sfc16_pkg::OFS_COMMAND:  fc_cmd = b;
          sfc16_pkg::OFS_STATUS:   fc_stat = b;
          sfc16_pkg::OFS_LEN_LO:   fc_length = {8'h00, b};
          sfc16_pkg::OFS_LEN_HI:   fc_length[15:8] = b;
          default: ;
        endcase
      end else begin
        off = pos - sfc16_pkg::HEADER_BYTES;
        if (off < plen) begin
          fc_crc = crc16_step(fc_crc, b);
          fwd    = hdr_ok;
        end else if (off == plen) begin
          fc_crc_low = b;
        end else if (off == plen + 1) begin
          // folding the wire CRC in leaves zero on a match
          fc_crc ^= {b, fc_crc_low};
        end
      end
      fc_index = 11'(pos + 1);
    end

    if (fwd) begin
      it         = '0;
      it.kind    = sfc16_pkg::KIND_PAYLOAD;
      it.pay     = b;
      it.run_end = !e;
      frame_results_due.push_back(it);
    end

    if (e) begin
      cnt  = fc_index;
      plen = fc_length;
      if (cnt < sfc16_pkg::HEADER_BYTES)                 v = sfc16_pkg::VERD_SHORT;
      else if (fc_magic_bad)                             v = sfc16_pkg::VERD_BAD_MAGIC;
      else if (fc_version_bad)                           v = sfc16_pkg::VERD_BAD_VERSION;
      else if (plen > sfc16_pkg::MAX_PAYLOAD)            v = sfc16_pkg::VERD_TOO_LONG;
      else if (cnt < sfc16_pkg::HEADER_BYTES + plen + 2) v = sfc16_pkg::VERD_SHORT;
      else if (fc_crc != 16'h0000)                       v = sfc16_pkg::VERD_BAD_CRC;
      else                                               v = sfc16_pkg::VERD_OK;
      it         = '0;
      it.kind    = sfc16_pkg::KIND_VERDICT;
      it.verdict = v;
      if (v == sfc16_pkg::VERD_OK) begin
        it.flags = fc_flags;
        it.seq   = fc_seq;
        it.cmd   = fc_cmd;
        it.stat  = fc_stat;
        it.len   = fc_length[10:0];
      end
      it.run_end = 1'b1;
      frame_results_due.push_back(it);
      clear_frame_state();
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  // Leaves tvalid high, so the caller drives the next item or drops tvalid.
  task automatic push_byte(input logic [7:0] b, input logic e, input logic typed,
                           input sfc16_pkg::verdict_t tverd);
    frame_item_t it;
    while (!steady && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= e;
    do @(posedge clk); while (!s_axis_tready);
    predict_byte(b, e);
    if (typed) begin
      it         = '0;
      it.kind    = sfc16_pkg::KIND_VERDICT;
      it.verdict = tverd;
      it.run_end = 1'b1;
      frame_results_due[frame_results_due.size() - 1] = it;
    end
    @(negedge clk);
  endtask

  task automatic send_buffer(input logic [7:0] q[$]);
    foreach (q[i]) push_byte(q[i], i == q.size() - 1, 1'b0, sfc16_pkg::VERD_OK);
  endtask

  // Hold until every owed item is out, then let the pipeline settle.
  task automatic wait_idle();
    while (frame_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      sfc16_pkg::REG_MAGIC_FIRST:  want_magic0 = val;
      sfc16_pkg::REG_MAGIC_SECOND: want_magic1 = val;
      sfc16_pkg::REG_VERSION:      want_version = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Build one received buffer: mostly good frames against the current registers,
  // the rest broken frames and noise. jumbo gives the longest payload plus
  // trailing bytes that push the index past its limit.
  task automatic make_buffer(input bit jumbo, output logic [7:0] q[$]);
    int          r, n;
    logic [15:0] len, c;
    logic [7:0]  m0, m1, ver;
    q   = {};
    r   = jumbo ? 0 : $urandom_range(99);
    m0  = want_magic0;
    m1  = want_magic1;
    ver = want_version;
    if (r >= 91) begin
      // noise
      n = $urandom_range(1, 24);
      repeat (n) q.push_back(8'($urandom));
      return;
    end
    if (r >= 60 && r <= 65) begin
      if ($urandom_range(1)) m0 ^= 8'($urandom_range(1, 255));
      else m1 ^= 8'($urandom_range(1, 255));
    end
    if (r >= 66 && r <= 70) ver ^= 8'($urandom_range(1, 255));
    if (jumbo) len = 16'(sfc16_pkg::MAX_PAYLOAD);
    else if ($urandom_range(9) == 0) len = 16'($urandom_range(13, 80));
    else len = 16'($urandom_range(0, 12));
    if (r >= 71 && r <= 75) begin
      case ($urandom_range(2))
        0:       len = 16'(sfc16_pkg::MAX_PAYLOAD + 1);
        1:       len = 16'hFFFF;
        default: len = 16'($urandom_range(sfc16_pkg::MAX_PAYLOAD + 2, 65534));
      endcase
    end
    q.push_back(m0);
    q.push_back(m1);
    q.push_back(ver);
    repeat (5) q.push_back(8'($urandom));  // flags, sequence, command, status, reserved
    q.push_back(len[7:0]);
    q.push_back(len[15:8]);
    if (len > sfc16_pkg::MAX_PAYLOAD) begin
      // oversize length: a few bytes of body, then the end mark
      n = $urandom_range(0, 6);
      repeat (n) q.push_back(8'($urandom));
      return;
    end
    repeat (len) q.push_back(8'($urandom));
    c = sfc16_pkg::CRC_SEED;
    foreach (q[i]) c = crc16_step(c, q[i]);
    if (r >= 84 && r <= 90) c ^= 16'(1 << $urandom_range(15));
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    if (jumbo) begin
      while (q.size() < JUMBO_BYTES) q.push_back(8'($urandom));
    end else if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 3);
      repeat (n) q.push_back(8'($urandom));
    end
    if (r >= 76 && r <= 83) begin
      // cut the frame short somewhere inside
      n = $urandom_range(1, q.size() - 1);
      while (q.size() > n) q.delete(q.size() - 1);
    end
  endtask

  // Output side: stall at random unless idling is off.
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 24);
  end

  // Check each item the block hands over against the oldest one owed, and
  // end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind    = m_axis_tuser;
        got.pay     = m_axis_tdata[7:0];
        got.verdict = sfc16_pkg::verdict_t'(m_axis_tdata[10:8]);
        got.flags   = m_axis_tdata[18:11];
        got.seq     = m_axis_tdata[26:19];
        got.cmd     = m_axis_tdata[34:27];
        got.stat    = m_axis_tdata[42:35];
        got.len     = m_axis_tdata[53:43];
        got.run_end = m_axis_tlast;
        if (frame_results_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected item: %s", item_text(got));
          mismatches++;
        end else begin
          want = frame_results_due.pop_front();
          if (got.kind != want.kind || got.pay != want.pay || got.verdict != want.verdict ||
              got.flags != want.flags || got.seq != want.seq || got.cmd != want.cmd ||
              got.stat != want.stat || got.len != want.len ||
              got.run_end != want.run_end) begin
            if (mismatches < 10) begin
              $display("mismatch at %0t", $time);
              $display("  expected %s", item_text(want));
              $display("  actual   %s", item_text(got));
            end
            mismatches++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] q[$];
    logic [7:0] b, v0, v1, v2;
    int         phase_bytes;
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    quiet_cycles  = 0;
    steady        = 1'b0;
    want_magic0   = '0;
    want_magic1   = '0;
    want_version  = '0;
    clear_frame_state();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed steps
    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) begin
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_reg(steps[i].reg_idx, steps[i].val);
      end else begin
        case (steps[i].src)
          SRC_CRC_LO: b = fc_crc[7:0];
          SRC_CRC_HI: b = fc_crc[15:8];
          default:    b = steps[i].val;
        endcase
        push_byte(b, steps[i].last, steps[i].typed, steps[i].tverd);
      end
    end

    // random phases: random registers, all zero with idling off, all ones, random
    for (int phase = 1; phase <= 4; phase++) begin
      s_axis_tvalid <= 1'b0;
      wait_idle();
      case (phase)
        2:       begin v0 = 8'h00; v1 = 8'h00; v2 = 8'h00; end
        3:       begin v0 = 8'hFF; v1 = 8'hFF; v2 = 8'hFF; end
        default: begin v0 = 8'($urandom); v1 = 8'($urandom); v2 = 8'($urandom); end
      endcase
      write_reg(sfc16_pkg::REG_MAGIC_FIRST, v0);
      write_reg(sfc16_pkg::REG_MAGIC_SECOND, v1);
      write_reg(sfc16_pkg::REG_VERSION, v2);
      steady      = (phase == 2);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        make_buffer(1'b0, q);
        send_buffer(q);
        phase_bytes += q.size();
      end
    end
    steady = 1'b0;

    s_axis_tvalid <= 1'b0;
    wait_idle();
    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
